/* hw/rtl/mfgs_pkg.sv */
`default_nettype none
package mfgs_pkg;

    // frame geometry
    localparam int FRAME_WIDTH  = 256;
    localparam int FRAME_HEIGHT = 64;
    localparam int ROW_BYTES    = (FRAME_WIDTH + 7) / 8;
    localparam int STORE_BYTES  = ROW_BYTES * FRAME_HEIGHT;
    localparam int ADDR_W       = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    // word layout
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;
    localparam int OUT_USER_W = 2;

    // header and step counting
    localparam int HDR_LEN   = 7;
    localparam int GRAY_LEN  = 4;
    localparam int STEP_W    = 3;

    // command codes
    localparam logic [1:0] CMD_PLOT  = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_SCAN  = 2'd2;

    // pen codes
    localparam logic [1:0] PEN_SET    = 2'd0;
    localparam logic [1:0] PEN_CLR    = 2'd1;
    localparam logic [1:0] PEN_INV    = 2'd2;
    localparam logic [1:0] PEN_NOCHG  = 2'd3;

    // gray nibbles
    localparam logic [3:0] NIB_ON  = 4'hf;
    localparam logic [3:0] NIB_OFF = 4'h0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PLOT_RD,
        ST_PLOT_WR,
        ST_SCAN_RD,
        ST_HDR,
        ST_GRAY
    } mfgs_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic plot_rd;
        logic plot_wr;
        logic clr_run;
        logic scan_rd;
        logic hdr_load;
        logic gray_load;
        logic cnt_clr;
        logic cnt_inc;
        logic ptr_adv;
    } mfgs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic load_ok;
        logic ptr_zero;
        logic hdr_last;
        logic gray_last;
        logic clr_done;
    } mfgs_status_t;

    // panel header: {is_data, byte}
    function automatic logic [8:0] hdr_word(input logic [STEP_W-1:0] idx);
        logic [8:0] w;
        case (idx)
            3'd0:    w = {1'b0, 8'h15};
            3'd1:    w = {1'b1, 8'h1c};
            3'd2:    w = {1'b1, 8'h5b};
            3'd3:    w = {1'b0, 8'h75};
            3'd4:    w = {1'b1, 8'h00};
            3'd5:    w = {1'b1, 8'h63};
            default: w = {1'b0, 8'h5c};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/mfgs_ram.sv */
`default_nettype none
module mfgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read that holds when idle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/mfgs_ctrl.sv */
`default_nettype none
module mfgs_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [1:0]            command,
    output mfgs_pkg::mfgs_cmd_t        cmd,
    input  wire mfgs_pkg::mfgs_status_t stat
);

    mfgs_pkg::mfgs_state_t state_reg, state_next;
    logic accept;

    assign s_tready = (state_reg == mfgs_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // state register, reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mfgs_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mfgs_pkg::ST_CLEAR:
            begin
                if (stat.clr_done)
                begin
                    state_next = mfgs_pkg::ST_IDLE;
                end
            end
            mfgs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        mfgs_pkg::CMD_PLOT:  state_next = mfgs_pkg::ST_PLOT_RD;
                        mfgs_pkg::CMD_CLEAR: state_next = mfgs_pkg::ST_CLEAR;
                        mfgs_pkg::CMD_SCAN:  state_next = mfgs_pkg::ST_SCAN_RD;
                        default:             state_next = mfgs_pkg::ST_IDLE;
                    endcase
                end
            end
            mfgs_pkg::ST_PLOT_RD: state_next = mfgs_pkg::ST_PLOT_WR;
            mfgs_pkg::ST_PLOT_WR: state_next = mfgs_pkg::ST_IDLE;
            mfgs_pkg::ST_SCAN_RD:
            begin
                state_next = stat.ptr_zero ? mfgs_pkg::ST_HDR : mfgs_pkg::ST_GRAY;
            end
            mfgs_pkg::ST_HDR:
            begin
                if (stat.load_ok && stat.hdr_last)
                begin
                    state_next = mfgs_pkg::ST_GRAY;
                end
            end
            mfgs_pkg::ST_GRAY:
            begin
                if (stat.load_ok && stat.gray_last)
                begin
                    state_next = mfgs_pkg::ST_IDLE;
                end
            end
            default: state_next = mfgs_pkg::ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            mfgs_pkg::ST_CLEAR:
            begin
                cmd.clr_run = 1'b1;
            end
            mfgs_pkg::ST_IDLE:
            begin
                cmd.capture = accept;
                cmd.cnt_clr = 1'b1;
            end
            mfgs_pkg::ST_PLOT_RD:
            begin
                cmd.plot_rd = 1'b1;
            end
            mfgs_pkg::ST_PLOT_WR:
            begin
                cmd.plot_wr = 1'b1;
            end
            mfgs_pkg::ST_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
            end
            mfgs_pkg::ST_HDR:
            begin
                cmd.hdr_load = stat.load_ok;
                cmd.cnt_clr  = stat.load_ok && stat.hdr_last;
                cmd.cnt_inc  = stat.load_ok && !stat.hdr_last;
            end
            mfgs_pkg::ST_GRAY:
            begin
                cmd.gray_load = stat.load_ok;
                cmd.cnt_inc   = stat.load_ok && !stat.gray_last;
                cmd.ptr_adv   = stat.load_ok && stat.gray_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/mfgs_datapath.sv */
`default_nettype none
module mfgs_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [mfgs_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [mfgs_pkg::OUT_DATA_W-1:0]          m_tdata,
    output logic                                     m_tlast,
    output logic [mfgs_pkg::OUT_USER_W-1:0]          m_tuser,
    input  wire mfgs_pkg::mfgs_cmd_t                 cmd,
    output mfgs_pkg::mfgs_status_t                   stat
);

    localparam int AW = mfgs_pkg::ADDR_W;

    logic [15:0] x_in, y_in;
    logic [1:0]  pen_in;
    logic        in_frame;
    logic [31:0] idx_full;

    logic          in_frame_reg;
    logic [AW-1:0] plot_addr_reg;
    logic [7:0]    bit_mask_reg;
    logic [1:0]    pen_reg;

    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [mfgs_pkg::STEP_W-1:0] step_reg, step_next;

    logic                          out_valid_reg, out_valid_next;
    logic [7:0]                    out_byte_reg, out_byte_next;
    logic                          out_data_reg, out_data_next;
    logic                          out_last_reg, out_last_next;
    logic                          out_fe_reg, out_fe_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;
    logic [7:0]    plot_byte;
    logic [1:0]    pix_pair;
    logic [8:0]    hdr_w;
    logic          ptr_last;

    // unpack the input word
    assign x_in   = s_tdata[15:0];
    assign y_in   = s_tdata[31:16];
    assign pen_in = s_tdata[33:32];

    // frame check and byte address
    assign in_frame = !x_in[15] && (x_in[14:0] < 15'(mfgs_pkg::FRAME_WIDTH))
                   && !y_in[15] && (y_in[14:0] < 15'(mfgs_pkg::FRAME_HEIGHT));
    assign idx_full = 32'(x_in[14:3]) + 32'(y_in[14:0]) * 32'(mfgs_pkg::ROW_BYTES);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_frame_reg  <= in_frame;
            plot_addr_reg <= idx_full[AW-1:0];
            bit_mask_reg  <= 8'h80 >> x_in[2:0];
            pen_reg       <= pen_in;
        end
    end

    // pen applied to the byte read back
    always_comb
    begin
        case (pen_reg)
            mfgs_pkg::PEN_SET: plot_byte = ram_rdata | bit_mask_reg;
            mfgs_pkg::PEN_CLR: plot_byte = ram_rdata & ~bit_mask_reg;
            mfgs_pkg::PEN_INV: plot_byte = ram_rdata ^ bit_mask_reg;
            default:           plot_byte = ram_rdata;
        endcase
    end

    // memory port muxing
    assign ram_we    = cmd.clr_run || (cmd.plot_wr && in_frame_reg
                                       && (pen_reg != mfgs_pkg::PEN_NOCHG));
    assign ram_waddr = cmd.clr_run ? clr_cnt_reg : plot_addr_reg;
    assign ram_wdata = cmd.clr_run ? 8'h00 : plot_byte;
    assign ram_re    = cmd.plot_rd || cmd.scan_rd;
    assign ram_raddr = cmd.plot_rd ? plot_addr_reg : ptr_reg;

    mfgs_ram #(
        .WIDTH (8),
        .DEPTH (mfgs_pkg::STORE_BYTES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // clear sweep, scan pointer and step counter
    assign ptr_last = (ptr_reg == AW'(mfgs_pkg::STORE_BYTES - 1));

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        if (cmd.clr_run)
        begin
            clr_cnt_next = stat.clr_done ? '0 : clr_cnt_reg + 1'b1;
        end
        ptr_next = ptr_reg;
        if (cmd.ptr_adv)
        begin
            ptr_next = ptr_last ? '0 : ptr_reg + 1'b1;
        end
        step_next = step_reg;
        if (cmd.cnt_clr)
        begin
            step_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            ptr_reg     <= '0;
            step_reg    <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            ptr_reg     <= ptr_next;
            step_reg    <= step_next;
        end
    end

    // gray expansion, left pixel in the high nibble
    always_comb
    begin
        case (step_reg[1:0])
            2'd0:    pix_pair = ram_rdata[7:6];
            2'd1:    pix_pair = ram_rdata[5:4];
            2'd2:    pix_pair = ram_rdata[3:2];
            default: pix_pair = ram_rdata[1:0];
        endcase
    end

    assign hdr_w = mfgs_pkg::hdr_word(step_reg);

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_fe_next    = out_fe_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.hdr_load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = hdr_w[7:0];
            out_data_next  = hdr_w[8];
            out_last_next  = 1'b0;
            out_fe_next    = 1'b0;
        end
        else if (cmd.gray_load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = {pix_pair[1] ? mfgs_pkg::NIB_ON : mfgs_pkg::NIB_OFF,
                              pix_pair[0] ? mfgs_pkg::NIB_ON : mfgs_pkg::NIB_OFF};
            out_data_next  = 1'b1;
            out_last_next  = stat.gray_last;
            out_fe_next    = stat.gray_last && ptr_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_fe_reg   <= out_fe_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_fe_reg, out_data_reg};

    // status to the controller
    assign stat.load_ok   = !out_valid_reg || m_tready;
    assign stat.ptr_zero  = (ptr_reg == '0);
    assign stat.hdr_last  = (step_reg == mfgs_pkg::STEP_W'(mfgs_pkg::HDR_LEN - 1));
    assign stat.gray_last = (step_reg == mfgs_pkg::STEP_W'(mfgs_pkg::GRAY_LEN - 1));
    assign stat.clr_done  = (clr_cnt_reg == AW'(mfgs_pkg::STORE_BYTES - 1));

endmodule
`default_nettype wire

/* hw/rtl/mono_framebuffer_gray_scanout.sv */
// plot: capture at accept, then read and write back, next word taken after that
// clear: one store byte zeroed per cycle by the sweep counter
// scan step: store byte read after accept, then one word per cycle while the output is not stalled
// (11 words at pointer zero, else 4), paced by the single output register
// reset: async active low; a clearing pass over all STORE_BYTES (2048) store bytes runs, s_tready low
`default_nettype none
module mono_framebuffer_gray_scanout (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // x_pos[15:0], y_pos[31:16], pen[33:32], zero pad[39:34]
    input  wire logic [mfgs_pkg::IN_DATA_W-1:0]   s_tdata,
    // command[1:0]
    input  wire logic [mfgs_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // out_byte[7:0]
    output logic [mfgs_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                  m_tlast,
    // is_data[0], frame_end[1]
    output logic [mfgs_pkg::OUT_USER_W-1:0]       m_tuser
);

    mfgs_pkg::mfgs_cmd_t    cmd;
    mfgs_pkg::mfgs_status_t stat;

    // sequencer
    mfgs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .command  (s_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

    // store, counters and output register
    mfgs_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
`default_nettype wire
